// ===== hdl/xrg_pkg.sv =====
// Shared types and constants of the xorshift64* range generator.
`default_nettype none
package xrg_pkg;

  localparam int unsigned HalfW  = 32;
  localparam int unsigned StateW = 64;

  localparam logic [StateW-1:0] GoldenMult = 64'h9E3779B97F4A7C15;
  localparam logic [StateW-1:0] OutputMult = 64'h2545F4914F6CDD1D;

  localparam int unsigned ShiftA = 12;
  localparam int unsigned ShiftB = 25;
  localparam int unsigned ShiftC = 27;

  localparam logic [1:0] OpRange  = 2'd0;
  localparam logic [1:0] OpRaw    = 2'd1;
  localparam logic [1:0] OpReseed = 2'd2;

  // Status of the remainder unit as seen by the sequencer.
  typedef struct packed {
    logic            done;
    logic [HalfW-1:0] rem;
  } div_status_t;

endpackage
`default_nettype wire

// ===== hdl/xrg_mul32.sv =====
// Shared 32 by 32 bit multiplier with a registered product.
`default_nettype none
module xrg_mul32 (
  input  wire logic                             clk_i,
  input  wire logic [xrg_pkg::HalfW-1:0]        a_i,
  input  wire logic [xrg_pkg::HalfW-1:0]        b_i,
  output logic      [2*xrg_pkg::HalfW-1:0]      prod_o
);

  logic [2*xrg_pkg::HalfW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= {{xrg_pkg::HalfW{1'b0}}, a_i} * {{xrg_pkg::HalfW{1'b0}}, b_i};
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== hdl/xrg_rem_div.sv =====
// Restoring divider that returns the remainder, one quotient bit per cycle.
`default_nettype none
module xrg_rem_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [xrg_pkg::HalfW-1:0] dividend_i,
  input  wire logic [xrg_pkg::HalfW-1:0] divisor_i,
  output xrg_pkg::div_status_t           status_o
);

  localparam int unsigned CntW = $clog2(xrg_pkg::HalfW);

  logic                      busy_q, done_q;
  logic [CntW-1:0]           cnt_q;
  logic [xrg_pkg::HalfW-1:0] rem_q, quo_q, dsr_q;
  logic [xrg_pkg::HalfW:0]   trial;
  logic [xrg_pkg::HalfW:0]   diff;

  assign trial = {rem_q, quo_q[xrg_pkg::HalfW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CntW'(xrg_pkg::HalfW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(xrg_pkg::HalfW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      // Keep the trial remainder when it is below the divisor.
      rem_q <= diff[xrg_pkg::HalfW] ? trial[xrg_pkg::HalfW-1:0]
                                    : diff[xrg_pkg::HalfW-1:0];
      quo_q <= {quo_q[xrg_pkg::HalfW-2:0], 1'b0};
    end
  end

  assign status_o.done = done_q;
  assign status_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== hdl/xorshift64star_range_generator.sv =====
// Top level of the xorshift64* range generator: sequencer, state and output register.
`default_nettype none
// One input word is taken at a time. A draw takes its xorshift step on
// acceptance, then three passes through one shared 32x32 multiplier build the
// upper half of the 64-bit scrambled product; a range draw with a nonzero
// span then runs the restoring remainder unit. An empty range or an unused
// code skips both the multiplier and the remainder unit. The result sits in
// an output register, and the next input word is accepted while it waits.
// A reseed with seed zero loads the state with the zero_seed_mix register.
module xorshift64star_range_generator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      zero_seed_mix_we_i,
  input  wire logic [63:0]               zero_seed_mix_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                operation_i,
  input  wire logic signed [31:0]        range_low_i,
  input  wire logic signed [31:0]        range_high_i,
  input  wire logic signed [31:0]        seed_value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [31:0]             random_value_o,
  output logic                           state_advanced_o
);

  localparam int unsigned HW = xrg_pkg::HalfW;
  localparam int unsigned SW = xrg_pkg::StateW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_DIV, ST_FIN
  } seq_e;

  seq_e             st_q;
  logic [SW-1:0]    state_q, mix_q, opnd_q, mult_q;
  logic [1:0]       op_q;
  logic             seed_zero_q;
  logic [HW-1:0]    lo_q, span_q, acc_lo_q, acc_hi_q, res_q;
  logic             adv_q;
  logic             out_valid_q;
  logic [HW-1:0]    out_val_q;
  logic             out_adv_q;

  logic [SW-1:0]    xs1, xs2, xs3;
  logic [HW-1:0]    mul_a, mul_b, acc_hi_new, span_in;
  logic [2*HW-1:0]  prod;
  logic             div_start;
  xrg_pkg::div_status_t div_st;
  logic             accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == ST_IDLE);

  // One xorshift step of the current state.
  assign xs1 = state_q ^ (state_q >> xrg_pkg::ShiftA);
  assign xs2 = xs1 ^ (xs1 << xrg_pkg::ShiftB);
  assign xs3 = xs2 ^ (xs2 >> xrg_pkg::ShiftC);

  assign span_in    = range_high_i - range_low_i + HW'(1);
  assign acc_hi_new = acc_hi_q + prod[HW-1:0];

  always_comb begin
    mul_a = opnd_q[HW-1:0];
    mul_b = mult_q[HW-1:0];
    case (st_q)
      ST_M1:   mul_b = mult_q[SW-1:HW];
      ST_M2:   mul_a = opnd_q[SW-1:HW];
      default: begin
      end
    endcase
  end

  assign div_start = (st_q == ST_M3) && (op_q == xrg_pkg::OpRange) && (span_q != '0);

  xrg_mul32 u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  xrg_rem_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_hi_new),
    .divisor_i  (span_q),
    .status_o   (div_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      state_q     <= xrg_pkg::GoldenMult;
      mix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (zero_seed_mix_we_i) begin
        mix_q <= zero_seed_mix_i;
      end
      if (out_valid_q && out_ready_i && (st_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            op_q        <= operation_i;
            lo_q        <= range_low_i;
            span_q      <= span_in;
            seed_zero_q <= (seed_value_i == '0);
            adv_q       <= 1'b0;
            case (operation_i)
              xrg_pkg::OpRange: begin
                if (range_high_i <= range_low_i) begin
                  res_q <= range_low_i;
                  st_q  <= ST_FIN;
                end else begin
                  state_q <= xs3;
                  opnd_q  <= xs3;
                  mult_q  <= xrg_pkg::OutputMult;
                  st_q    <= ST_M0;
                end
              end
              xrg_pkg::OpRaw: begin
                state_q <= xs3;
                opnd_q  <= xs3;
                mult_q  <= xrg_pkg::OutputMult;
                st_q    <= ST_M0;
              end
              xrg_pkg::OpReseed: begin
                res_q  <= '0;
                opnd_q <= {{HW{seed_value_i[HW-1]}}, seed_value_i};
                mult_q <= xrg_pkg::GoldenMult;
                st_q   <= ST_M0;
              end
              default: begin
                res_q <= '0;
                st_q  <= ST_FIN;
              end
            endcase
          end
        end
        ST_M0: st_q <= ST_M1;
        ST_M1: begin
          acc_lo_q <= prod[HW-1:0];
          acc_hi_q <= prod[2*HW-1:HW];
          st_q     <= ST_M2;
        end
        ST_M2: begin
          acc_hi_q <= acc_hi_new;
          st_q     <= ST_M3;
        end
        ST_M3: begin
          case (op_q)
            xrg_pkg::OpReseed: begin
              state_q <= seed_zero_q ? mix_q : {acc_hi_new, acc_lo_q};
              st_q    <= ST_FIN;
            end
            xrg_pkg::OpRaw: begin
              res_q <= acc_hi_new;
              adv_q <= 1'b1;
              st_q  <= ST_FIN;
            end
            default: begin
              adv_q <= 1'b1;
              // A span that wrapped to zero covers every 32-bit value.
              if (span_q == '0) begin
                res_q <= lo_q + acc_hi_new;
                st_q  <= ST_FIN;
              end else begin
                st_q <= ST_DIV;
              end
            end
          endcase
        end
        ST_DIV: begin
          if (div_st.done) begin
            res_q <= lo_q + div_st.rem;
            st_q  <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_q;
            out_adv_q   <= adv_q;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign random_value_o   = out_val_q;
  assign state_advanced_o = out_adv_q;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the xorshift64* range generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned IdlePercent = 14;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned LongStall   = 400;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] seed;
  } input_word_t;

  typedef struct {
    logic [31:0] value;
    logic        advanced;
  } draw_result_t;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               zero_seed_mix_we_i = 1'b0;
  logic [63:0]        zero_seed_mix_i    = '0;
  logic               in_valid_i         = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i        = '0;
  logic signed [31:0] range_low_i        = '0;
  logic signed [31:0] range_high_i       = '0;
  logic signed [31:0] seed_value_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i        = 1'b0;
  logic signed [31:0] random_value_o;
  logic               state_advanced_o;

  // Shadow copy of the generator and its register.
  logic [63:0]  model_state;
  logic [63:0]  model_mix;
  draw_result_t expected_draws[$];

  bit          idle_on       = 1'b0;
  int unsigned stall_request = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  xorshift64star_range_generator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .zero_seed_mix_we_i(zero_seed_mix_we_i),
    .zero_seed_mix_i   (zero_seed_mix_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .range_low_i       (range_low_i),
    .range_high_i      (range_high_i),
    .seed_value_i      (seed_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .random_value_o    (random_value_o),
    .state_advanced_o  (state_advanced_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic [31:0] step_state();
    logic [63:0] x;
    logic [63:0] product;
    x = model_state;
    x = x ^ (x >> xrg_pkg::ShiftA);
    x = x ^ (x << xrg_pkg::ShiftB);
    x = x ^ (x >> xrg_pkg::ShiftC);
    model_state = x;
    product = x * xrg_pkg::OutputMult;
    return product[63:32];
  endfunction

  function automatic draw_result_t compute_draw(input input_word_t w);
    draw_result_t res;
    logic [31:0]  span;
    logic [31:0]  raw;
    res.value    = '0;
    res.advanced = 1'b0;
    case (w.op)
      xrg_pkg::OpRange: begin
        if ($signed(w.hi) <= $signed(w.lo)) begin
          res.value = w.lo;
        end else begin
          span = w.hi - w.lo + 32'd1;
          raw  = step_state();
          res.advanced = 1'b1;
          // A span that wraps to zero covers every 32-bit value.
          res.value = (span == '0) ? w.lo + raw : w.lo + raw % span;
        end
      end
      xrg_pkg::OpRaw: begin
        res.value    = step_state();
        res.advanced = 1'b1;
      end
      xrg_pkg::OpReseed: begin
        model_state = {{32{w.seed[31]}}, w.seed} * xrg_pkg::GoldenMult;
        if (w.seed == '0) model_state = model_state ^ model_mix;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic input_word_t make_word(input logic [1:0] op, input logic [31:0] lo,
                                            input logic [31:0] hi, input logic [31:0] seed);
    input_word_t w;
    w.op   = op;
    w.lo   = lo;
    w.hi   = hi;
    w.seed = seed;
    return w;
  endfunction

  function automatic input_word_t random_word();
    input_word_t w;
    int unsigned pick;
    w.lo   = $urandom;
    w.hi   = $urandom;
    w.seed = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
    pick   = $urandom_range(99);
    if (pick < 55)      w.op = xrg_pkg::OpRange;
    else if (pick < 80) w.op = xrg_pkg::OpRaw;
    else if (pick < 93) w.op = xrg_pkg::OpReseed;
    else                w.op = OpUnused;
    if (w.op == xrg_pkg::OpRange) begin
      case ($urandom_range(5))
        0, 1: w.hi = w.lo + $urandom_range(1000);
        2:    w.hi = w.lo + $urandom_range(3);
        3: begin
          w.lo = 32'h8000_0000 + $urandom_range(3);
          w.hi = 32'h7FFF_FFFF - $urandom_range(3);
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Called at a rising edge; leaves valid high so back-to-back words need no toggle.
  task automatic send_word(input input_word_t w);
    int unsigned gap;
    gap = (idle_on && $urandom_range(99) < IdlePercent) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= w.op;
    range_low_i  <= w.lo;
    range_high_i <= w.hi;
    seed_value_i <= w.seed;
    do @(posedge clk_i); while (!in_ready_o);
    expected_draws.push_back(compute_draw(w));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_seed_mix(input logic [63:0] mix);
    wait_for_results();
    zero_seed_mix_we_i <= 1'b1;
    zero_seed_mix_i    <= mix;
    @(posedge clk_i);
    zero_seed_mix_we_i <= 1'b0;
    model_mix = mix;
  endtask

  task automatic test_directed();
    send_word(make_word(xrg_pkg::OpRaw,    32'h0,         32'h0,         32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'd0,         32'd9,         32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'd5,         32'd5,         32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'd10,        -32'sd3,       32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'h8000_0000, 32'h7FFF_FFFE, 32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'h8000_0000, 32'h8000_0001, 32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0));
    send_word(make_word(xrg_pkg::OpRange,  -32'sd100,     32'd100,       32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'd0,         32'd1,         32'h0));
    send_word(make_word(OpUnused,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(xrg_pkg::OpReseed, 32'h0,         32'h0,         32'd1));
    send_word(make_word(xrg_pkg::OpRaw,    32'h0,         32'h0,         32'h0));
    send_word(make_word(xrg_pkg::OpReseed, 32'h0,         32'h0,         32'hFFFF_FFFF));
    send_word(make_word(xrg_pkg::OpRange,  32'd0,         32'd999,       32'h0));
    send_word(make_word(xrg_pkg::OpReseed, 32'h0,         32'h0,         32'h7FFF_FFFF));
    send_word(make_word(xrg_pkg::OpRaw,    32'h0,         32'h0,         32'h0));
    send_word(make_word(xrg_pkg::OpReseed, 32'h0,         32'h0,         32'h8000_0000));
    send_word(make_word(xrg_pkg::OpRaw,    32'h0,         32'h0,         32'h0));
    // With the mix register still zero, a zero seed parks the generator at zero.
    send_word(make_word(xrg_pkg::OpReseed, 32'h0,         32'h0,         32'h0));
    send_word(make_word(xrg_pkg::OpRaw,    32'h0,         32'h0,         32'h0));
    send_word(make_word(xrg_pkg::OpRange,  -32'sd5,       32'd5,         32'h0));
    send_word(make_word(xrg_pkg::OpRange,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_word(make_word(xrg_pkg::OpReseed, 32'h0,         32'h0,         32'd12345));
  endtask

  task automatic test_seed_mix();
    logic [63:0] mixes[5];
    mixes = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h1,
              {$urandom, $urandom}, 64'h0};
    foreach (mixes[i]) begin
      write_seed_mix(mixes[i]);
      send_word(make_word(xrg_pkg::OpReseed, $urandom, $urandom, 32'h0));
      send_word(make_word(xrg_pkg::OpRaw, $urandom, $urandom, $urandom));
      send_word(make_word(xrg_pkg::OpRange, -32'sd1000, 32'd1000, $urandom));
    end
  endtask

  // The receiver stops for a long stretch so the output register fills and
  // the input side backs up; afterwards the sender waits for a full drain.
  task automatic test_output_stall();
    stall_request = LongStall;
    repeat (12) send_word(random_word());
    wait_for_results();
  endtask

  task automatic test_random_stream(input int unsigned count);
    repeat (count) send_word(random_word());
  endtask

  always @(posedge clk_i) begin
    draw_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected word: random_value %h state_advanced %b",
               random_value_o, state_advanced_o);
        error_count++;
      end else begin
        exp_res = expected_draws.pop_front();
        if (random_value_o !== exp_res.value) begin
          $error("random_value: expected %h, got %h", exp_res.value, random_value_o);
          error_count++;
        end
        if (state_advanced_o !== exp_res.advanced) begin
          $error("state_advanced: expected %b, got %b", exp_res.advanced, state_advanced_o);
          error_count++;
        end
      end
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= !(idle_on && $urandom_range(99) < IdlePercent);
      end
    end
  end

  initial begin
    model_state = xrg_pkg::GoldenMult;
    model_mix   = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    idle_on = 1'b1;
    test_seed_mix();
    test_output_stall();
    write_seed_mix({$urandom, $urandom});
    idle_on = 1'b0;
    test_random_stream(300);
    idle_on = 1'b1;
    test_random_stream(350);
    write_seed_mix(64'hFFFF_FFFF_FFFF_FFFF);
    test_random_stream(350);
    test_output_stall();
    write_seed_mix({$urandom, $urandom});
    test_random_stream(350);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/xrg_pkg.sv
hdl/xrg_mul32.sv
hdl/xrg_rem_div.sv
hdl/xorshift64star_range_generator.sv
test/tb_top.sv
